[src/rotated_blit_address_generator_unit_macros.svh]
// Assertion macros used by the blit address generator walker module
`ifndef ROTATED_BLIT_ADDRESS_GENERATOR_UNIT_MACROS_SVH
`define ROTATED_BLIT_ADDRESS_GENERATOR_UNIT_MACROS_SVH

// Check a property on every rising clk edge outside reset
`define RBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define RBA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[src/rba_pkg.sv]
// Types and constants of the rotated blit address generator
package rba_pkg;

  // Display geometry
  localparam int DISPLAY_WIDTH  = 320;
  localparam int DISPLAY_HEIGHT = 240;

  // Signed coordinate width: 12-bit offset plus 11-bit walk position
  localparam int CRD_W = 14;

  typedef logic signed [CRD_W-1:0] crd_t;

  localparam crd_t DISP_W_CRD = CRD_W'(DISPLAY_WIDTH);
  localparam crd_t DISP_H_CRD = CRD_W'(DISPLAY_HEIGHT);

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Rotation codes
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // Input item
  typedef struct packed {
    logic               operation;
    logic        [10:0] blit_width;
    logic        [10:0] blit_height;
    logic        [1:0]  rotation;
    logic signed [11:0] dst_x_offset;
    logic signed [11:0] dst_y_offset;
    logic signed [11:0] src_x_offset;
    logic signed [11:0] src_y_offset;
    logic        [10:0] source_width;
    logic        [10:0] source_height;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [21:0] src_index;
    logic [16:0] dst_index;
    logic        write_enable;
    logic        last;
  } out_item_t;

  // Clipped coordinates handed from the walker to the index unit
  typedef struct packed {
    logic        we;
    logic        last;
    logic [10:0] sx;
    logic [10:0] sy;
    logic [10:0] src_w;
    logic [10:0] dx;
    logic [10:0] dy;
  } rba_job_t;

endpackage

[src/rba_walker.sv]
// Descriptor store, output walk counters and clipping stage
module rba_walker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rba_pkg::in_item_t  in_data,
  output logic               job_valid,
  input  logic               job_stall,
  output rba_pkg::rba_job_t  job
);

  `include "rotated_blit_address_generator_unit_macros.svh"

  logic               busy_r, busy_nxt;
  logic               rejected_r, rejected_nxt;
  logic        [10:0] width_r, height_r;
  logic        [1:0]  rot_r;
  logic signed [11:0] dst_x_r, dst_y_r, src_x_r, src_y_r;
  logic        [21:0] src_dims_r;
  logic        [10:0] line_r, line_nxt;
  logic        [10:0] col_r, col_nxt;
  logic               job_valid_r, job_valid_nxt;
  rba_pkg::rba_job_t  job_r, job_nxt;

  logic               accept;
  logic               accept_start;
  logic               accept_step;
  logic               swap;
  logic        [10:0] out_w, out_h;
  logic               col_end, line_end, walk_last;
  logic               rejected_new;
  rba_pkg::crd_t      line_s, col_s, w_s, h_s;
  rba_pkg::crd_t      bx, by, sx, sy, dx, dy;
  rba_pkg::crd_t      src_w_s, src_h_s;
  logic               we;

  // Stall the input only while a computed job cannot move on
  assign in_stall     = job_valid_r && job_stall;
  assign accept       = in_valid && !in_stall;
  assign accept_start = accept && (in_data.operation == rba_pkg::OP_START);
  assign accept_step  = accept && (in_data.operation == rba_pkg::OP_STEP);

  // Map the output position back to the source block and clip it
  always_comb begin
    swap    = (rot_r == rba_pkg::ROT_90) || (rot_r == rba_pkg::ROT_270);
    out_w   = swap ? height_r : width_r;
    out_h   = swap ? width_r : height_r;
    line_s  = $signed({3'b000, line_r});
    col_s   = $signed({3'b000, col_r});
    w_s     = $signed({3'b000, width_r});
    h_s     = $signed({3'b000, height_r});
    src_w_s = $signed({3'b000, src_dims_r[10:0]});
    src_h_s = $signed({3'b000, src_dims_r[21:11]});
    case (rot_r)
      rba_pkg::ROT_90: begin
        bx = line_s;
        by = h_s - rba_pkg::crd_t'(1) - col_s;
      end
      rba_pkg::ROT_180: begin
        bx = w_s - rba_pkg::crd_t'(1) - col_s;
        by = h_s - rba_pkg::crd_t'(1) - line_s;
      end
      rba_pkg::ROT_270: begin
        bx = w_s - rba_pkg::crd_t'(1) - line_s;
        by = col_s;
      end
      default: begin
        bx = col_s;
        by = line_s;
      end
    endcase
    dx = $signed({{2{dst_x_r[11]}}, dst_x_r}) + col_s;
    dy = $signed({{2{dst_y_r[11]}}, dst_y_r}) + line_s;
    sx = $signed({{2{src_x_r[11]}}, src_x_r}) + bx;
    sy = $signed({{2{src_y_r[11]}}, src_y_r}) + by;
    we = (dx >= rba_pkg::crd_t'(0)) && (dx < rba_pkg::DISP_W_CRD) &&
         (dy >= rba_pkg::crd_t'(0)) && (dy < rba_pkg::DISP_H_CRD) &&
         (sx >= rba_pkg::crd_t'(0)) && (sx < src_w_s) &&
         (sy >= rba_pkg::crd_t'(0)) && (sy < src_h_s);
    col_end   = ({1'b0, col_r} + 12'd1) >= {1'b0, out_w};
    line_end  = ({1'b0, line_r} + 12'd1) >= {1'b0, out_h};
    walk_last = col_end && line_end;
    rejected_new = (in_data.blit_width == 11'd0) || (in_data.blit_height == 11'd0) ||
                   ($signed({{2{in_data.dst_x_offset[11]}}, in_data.dst_x_offset})
                     >= rba_pkg::DISP_W_CRD) ||
                   ($signed({{2{in_data.dst_y_offset[11]}}, in_data.dst_y_offset})
                     >= rba_pkg::DISP_H_CRD);
  end

  // Advance the walk state and form the next job
  always_comb begin
    busy_nxt      = busy_r;
    rejected_nxt  = rejected_r;
    line_nxt      = line_r;
    col_nxt       = col_r;
    job_valid_nxt = job_valid_r && job_stall;
    job_nxt       = job_r;
    if (accept_start) begin
      busy_nxt      = 1'b1;
      rejected_nxt  = rejected_new;
      line_nxt      = '0;
      col_nxt       = '0;
      job_valid_nxt = 1'b0;
    end else if (accept_step) begin
      job_valid_nxt = 1'b1;
      if (!busy_r || rejected_r) begin
        busy_nxt     = 1'b0;
        rejected_nxt = 1'b0;
        job_nxt      = '{we: 1'b0, last: 1'b1, default: '0};
      end else begin
        job_nxt.we    = we;
        job_nxt.last  = walk_last;
        job_nxt.sx    = sx[10:0];
        job_nxt.sy    = sy[10:0];
        job_nxt.src_w = src_dims_r[10:0];
        job_nxt.dx    = dx[10:0];
        job_nxt.dy    = dy[10:0];
        if (walk_last) begin
          busy_nxt = 1'b0;
        end else if (col_end) begin
          col_nxt  = '0;
          line_nxt = line_r + 11'd1;
        end else begin
          col_nxt = col_r + 11'd1;
        end
      end
    end
  end

  // Hold the descriptor and the stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      rejected_r  <= 1'b0;
      line_r      <= '0;
      col_r       <= '0;
      job_valid_r <= 1'b0;
      width_r     <= '0;
      height_r    <= '0;
      rot_r       <= rba_pkg::ROT_0;
      dst_x_r     <= '0;
      dst_y_r     <= '0;
      src_x_r     <= '0;
      src_y_r     <= '0;
      src_dims_r  <= '0;
    end else begin
      busy_r      <= busy_nxt;
      rejected_r  <= rejected_nxt;
      line_r      <= line_nxt;
      col_r       <= col_nxt;
      job_valid_r <= job_valid_nxt;
      if (accept_start) begin
        width_r    <= in_data.blit_width;
        height_r   <= in_data.blit_height;
        rot_r      <= in_data.rotation;
        dst_x_r    <= in_data.dst_x_offset;
        dst_y_r    <= in_data.dst_y_offset;
        src_x_r    <= in_data.src_x_offset;
        src_y_r    <= in_data.src_y_offset;
        src_dims_r <= {in_data.source_height, in_data.source_width};
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;

  // A start transfer yields no job
  `RBA_ASSERT(a_start_no_job, (accept_start |=> !job_valid_r), "start produced a job")
  // A step while idle answers an unwritten last position
  `RBA_ASSERT(a_idle_step, ((accept_step && !busy_r) |=> (job_valid_r && job_r.last && !job_r.we)), "idle step not answered as last")
  // A written position lies inside the source row
  `RBA_ASSERT_IMPLY(a_we_in_src, job_valid_r && job_r.we, job_r.sx < job_r.src_w, "written column outside source")

endmodule

[src/rba_index_unit.sv]
// Linear index computation and result register
module rba_index_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_stall,
  input  rba_pkg::rba_job_t  job,
  output logic               out_valid,
  input  logic               out_stall,
  output rba_pkg::out_item_t out_data
);

  localparam logic [21:0] DST_MUL = 22'(rba_pkg::DISPLAY_WIDTH);

  logic               out_valid_r, out_valid_nxt;
  rba_pkg::out_item_t out_data_r, out_data_nxt;
  logic               take;
  logic [21:0]        src_full;
  logic [21:0]        dst_full;

  // Take a job whenever the result register is free or being emptied
  assign job_stall = out_valid_r && out_stall;
  assign take      = job_valid && !job_stall;

  // Form both linear indices; zero them for a clipped position
  always_comb begin
    src_full = ({11'b0, job.sy} * {11'b0, job.src_w}) + {11'b0, job.sx};
    dst_full = ({11'b0, job.dy} * DST_MUL) + {11'b0, job.dx};
    out_data_nxt.src_index    = job.we ? src_full : '0;
    out_data_nxt.dst_index    = job.we ? dst_full[16:0] : '0;
    out_data_nxt.write_enable = job.we;
    out_data_nxt.last         = job.last;
    out_valid_nxt = take || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/rotated_blit_address_generator_unit.sv]
// A step result passes the job and result registers; a start gives none.
// Throughput: one item per cycle while no stall backs up from the result side.
// Index multiply sits in its own stage after the clipping stage.
// Reset (rst_n low, synchronous): idle, descriptor and counters cleared, no result.
// Stalls on the result side back up through both stages to in_stall.
module rotated_blit_address_generator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rba_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rba_pkg::out_item_t out_data
);

  logic              job_valid;
  logic              job_stall;
  rba_pkg::rba_job_t job;

  // Walk and clip
  rba_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .job       (job)
  );

  // Compute indices and hold the result
  rba_index_unit u_index (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .job       (job),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
